[hdl/qrfc_pkg.sv]
package qrfc_pkg;

   localparam int OUT_BITS = 24;

   localparam logic [7:0] CHAR_NL    = 8'd10;
   localparam logic [7:0] CHAR_LT    = 8'h3c;
   localparam logic [7:0] CHAR_GT    = 8'h3e;
   localparam logic [7:0] CHAR_PLUS  = 8'h2b;
   localparam logic [7:0] CHAR_COLON = 8'h3a;
   localparam logic [7:0] CHAR_DOT   = 8'h2e;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TILDE = 8'h7e;

   localparam logic [3:0] HDR_LEN = 4'd13;
   localparam logic [2:0] END_LEN = 3'd4;

   typedef enum logic [3:0] {
      PH_HDR      = 4'd0,
      PH_LSTART   = 4'd1,
      PH_END      = 4'd2,
      PH_DOT      = 4'd3,
      PH_NAME     = 4'd4,
      PH_TYPE     = 4'd5,
      PH_SIZE     = 4'd6,
      PH_DATA     = 4'd7,
      PH_DCOLON   = 4'd8,
      PH_PEND     = 4'd9,
      PH_FINISHED = 4'd10
   } phase_type;

   typedef enum logic [2:0] {
      ST_ACCEPTED = 3'd0,
      ST_PROPERTY = 3'd1,
      ST_OBJECT   = 3'd2,
      ST_FINISHED = 3'd3,
      ST_ERROR    = 3'd4
   } status_type;

   typedef enum logic [3:0] {
      ERR_NONE       = 4'd0,
      ERR_BAD_START  = 4'd1,
      ERR_BAD_HEADER = 4'd2,
      ERR_NO_PLUS    = 4'd3,
      ERR_NO_DOT     = 4'd4,
      ERR_NO_COLON   = 4'd5,
      ERR_NONDIGIT   = 4'd6,
      ERR_EXTRA_DATA = 4'd7,
      ERR_PREMATURE  = 4'd8
   } err_type;

   typedef struct packed {
      status_type           status;
      err_type              error_code;
      logic [OUT_BITS-1:0]  line_number;
      logic [OUT_BITS-1:0]  prop_type;
      logic [OUT_BITS-1:0]  prop_size;
      logic [OUT_BITS-1:0]  nonprint_count;
      logic [OUT_BITS-1:0]  object_count;
   } qrfc_result_type;

   // Expected bytes of the object start line "<Obj:1:msg:1:".
   function automatic logic [7:0] hdr_char(input logic [3:0] idx);
      logic [7:0] c;
      unique case (idx)
         4'd0:    c = CHAR_LT;
         4'd1:    c = 8'h4f;
         4'd2:    c = 8'h62;
         4'd3:    c = 8'h6a;
         4'd4:    c = CHAR_COLON;
         4'd5:    c = 8'h31;
         4'd6:    c = CHAR_COLON;
         4'd7:    c = 8'h6d;
         4'd8:    c = 8'h73;
         4'd9:    c = 8'h67;
         4'd10:   c = CHAR_COLON;
         4'd11:   c = 8'h31;
         4'd12:   c = CHAR_COLON;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   // Expected bytes of the closing line ">End".
   function automatic logic [7:0] end_char(input logic [1:0] idx);
      logic [7:0] c;
      unique case (idx)
         2'd0: c = CHAR_GT;
         2'd1: c = 8'h45;
         2'd2: c = 8'h6e;
         2'd3: c = 8'h64;
      endcase
      return c;
   endfunction

endpackage

[hdl/queue_record_format_checker.sv]
// Channel  Ports                        Direction  Word
// req      req_valid/req_stall          in         kind, byte_value
// rsp      rsp_valid/rsp_stall          out        status, error_code, counts
//
// One file byte is taken per cycle while req_stall is low; its result is
// registered in the output buffer. The per-byte state update is a single
// step of the parser state machine, so throughput is one word per cycle
// while req_stall is low. Reset is synchronous and returns the parser to
// the start of an object. A two-entry output buffer lets a word be accepted
// while a result waits; req_stall rises only when both entries hold words.
module queue_record_format_checker #(
   parameter int COUNT_BITS = 24
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_kind,
   input  logic [7:0]  req_byte_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [3:0]  rsp_error_code,
   output logic [23:0] rsp_line_number,
   output logic [23:0] rsp_prop_type,
   output logic [23:0] rsp_prop_size,
   output logic [23:0] rsp_nonprint_count,
   output logic [23:0] rsp_object_count
);
   import qrfc_pkg::*;

   logic            accept;
   logic            buf_full;
   qrfc_result_type core_result;
   qrfc_result_type rsp_data;

   assign accept    = req_valid && !buf_full;
   assign req_stall = buf_full;

   qrfc_core #(
      .COUNT_BITS (COUNT_BITS)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .kind       (req_kind),
      .byte_value (req_byte_value),
      .result     (core_result)
   );

   qrfc_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .in_data   (core_result),
      .full      (buf_full),
      .out_valid (rsp_valid),
      .out_data  (rsp_data),
      .out_stall (rsp_stall)
   );

   assign rsp_status         = rsp_data.status;
   assign rsp_error_code     = rsp_data.error_code;
   assign rsp_line_number    = rsp_data.line_number;
   assign rsp_prop_type      = rsp_data.prop_type;
   assign rsp_prop_size      = rsp_data.prop_size;
   assign rsp_nonprint_count = rsp_data.nonprint_count;
   assign rsp_object_count   = rsp_data.object_count;

endmodule

[hdl/qrfc_core.sv]
module qrfc_core #(
   parameter int COUNT_BITS = 24
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     accept,
   input  logic                     kind,
   input  logic [7:0]               byte_value,
   output qrfc_pkg::qrfc_result_type result
);
   import qrfc_pkg::*;

   localparam int WIDE_BITS = COUNT_BITS + 4;

   phase_type             phase_ff, phase_in;
   logic [3:0]            match_ff, match_in;
   logic [COUNT_BITS-1:0] acc_ff, acc_in;
   logic [COUNT_BITS-1:0] type_ff, type_in;
   logic [COUNT_BITS-1:0] remain_ff, remain_in;
   logic [COUNT_BITS-1:0] np_ff, np_in;
   logic [COUNT_BITS-1:0] line_ff, line_in;
   logic [COUNT_BITS-1:0] obj_ff, obj_in;
   err_type               sticky_ff, sticky_in;

   err_type               byte_err;
   logic                  obj_done;
   logic                  prop_done;
   logic                  finish_ok;
   logic                  is_digit;
   logic                  is_nonprint;
   logic [WIDE_BITS-1:0]  acc_wide;
   logic [COUNT_BITS-1:0] acc_next;

   function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
      return (v == {COUNT_BITS{1'b1}}) ? v : v + 1'b1;
   endfunction

   assign is_digit    = (byte_value >= CHAR_ZERO) && (byte_value <= CHAR_NINE);
   assign is_nonprint = (byte_value < CHAR_SPACE) || (byte_value > CHAR_TILDE);
   assign finish_ok   = ((phase_ff == PH_HDR) && (match_ff == 4'd0)) ||
                        ((phase_ff == PH_DOT) && (match_ff == 4'd1));

   // acc * 10 + digit, built from two shifts; the top four bits flag overflow.
   assign acc_wide = ({4'b0000, acc_ff} << 3) + ({4'b0000, acc_ff} << 1) +
                     WIDE_BITS'(byte_value[3:0]);
   assign acc_next = (acc_wide[WIDE_BITS-1:COUNT_BITS] != 4'd0) ?
                     {COUNT_BITS{1'b1}} : acc_wide[COUNT_BITS-1:0];

   always_comb begin
      phase_in  = phase_ff;
      match_in  = match_ff;
      acc_in    = acc_ff;
      type_in   = type_ff;
      remain_in = remain_ff;
      np_in     = np_ff;
      line_in   = line_ff;
      obj_in    = obj_ff;
      sticky_in = sticky_ff;
      byte_err  = ERR_NONE;
      obj_done  = 1'b0;
      prop_done = 1'b0;
      if (sticky_ff == ERR_NONE && phase_ff != PH_FINISHED) begin
         if (kind) begin
            if (finish_ok) begin
               phase_in = PH_FINISHED;
               if (phase_ff == PH_DOT) begin
                  obj_in = sat_inc(obj_ff);
               end
            end else begin
               sticky_in = ERR_PREMATURE;
            end
         end else begin
            unique case (phase_ff)
               PH_HDR: begin
                  if (match_ff < HDR_LEN) begin
                     if (byte_value == hdr_char(match_ff)) match_in = match_ff + 4'd1;
                     else byte_err = (match_ff == 4'd0) ? ERR_BAD_START : ERR_BAD_HEADER;
                  end else if (byte_value == CHAR_NL) begin
                     phase_in = PH_LSTART;
                     match_in = 4'd0;
                  end else begin
                     byte_err = ERR_BAD_HEADER;
                  end
               end
               PH_LSTART: begin
                  if (byte_value == CHAR_PLUS) begin
                     phase_in = PH_NAME;
                  end else if (byte_value == CHAR_GT) begin
                     phase_in = PH_END;
                     match_in = 4'd1;
                  end else begin
                     byte_err = ERR_NO_PLUS;
                  end
               end
               PH_END: begin
                  if (match_ff < 4'(END_LEN)) begin
                     if (byte_value == end_char(match_ff[1:0])) match_in = match_ff + 4'd1;
                     else byte_err = ERR_NO_PLUS;
                  end else if (byte_value == CHAR_NL) begin
                     phase_in = PH_DOT;
                     match_in = 4'd0;
                  end else begin
                     byte_err = ERR_NO_PLUS;
                  end
               end
               PH_DOT: begin
                  if (match_ff == 4'd0) begin
                     if (byte_value == CHAR_DOT) match_in = 4'd1;
                     else byte_err = ERR_NO_DOT;
                  end else if (byte_value == CHAR_NL) begin
                     obj_in   = sat_inc(obj_ff);
                     phase_in = PH_HDR;
                     match_in = 4'd0;
                     obj_done = 1'b1;
                  end else begin
                     byte_err = ERR_NO_DOT;
                  end
               end
               PH_NAME: begin
                  if (byte_value == CHAR_COLON) begin
                     phase_in = PH_TYPE;
                     acc_in   = '0;
                  end else if (byte_value == CHAR_NL) begin
                     byte_err = ERR_NO_COLON;
                  end
               end
               PH_TYPE, PH_SIZE: begin
                  if (byte_value == CHAR_COLON) begin
                     if (phase_ff == PH_TYPE) begin
                        type_in  = acc_ff;
                        acc_in   = '0;
                        phase_in = PH_SIZE;
                     end else begin
                        remain_in = acc_ff;
                        np_in     = '0;
                        phase_in  = (acc_ff == '0) ? PH_DCOLON : PH_DATA;
                     end
                  end else if (byte_value == CHAR_NL) begin
                     byte_err = ERR_NO_COLON;
                  end else if (!is_digit) begin
                     byte_err = ERR_NONDIGIT;
                  end else begin
                     acc_in = acc_next;
                  end
               end
               PH_DATA: begin
                  if (is_nonprint) np_in = sat_inc(np_ff);
                  if (remain_ff != '0) remain_in = remain_ff - 1'b1;
                  if (remain_ff <= COUNT_BITS'(1)) phase_in = PH_DCOLON;
               end
               PH_DCOLON: begin
                  if (byte_value == CHAR_COLON) phase_in = PH_PEND;
                  else byte_err = ERR_NO_COLON;
               end
               PH_PEND: begin
                  if (byte_value == CHAR_NL) begin
                     phase_in  = PH_LSTART;
                     prop_done = 1'b1;
                  end else begin
                     byte_err = ERR_EXTRA_DATA;
                  end
               end
               default: begin
                  byte_err = ERR_BAD_HEADER;
               end
            endcase
            // Every newline that is taken without error advances the line count,
            // data newlines included.
            if (byte_err != ERR_NONE) begin
               sticky_in = byte_err;
            end else if (byte_value == CHAR_NL) begin
               line_in = sat_inc(line_ff);
            end
         end
      end
   end

   always_comb begin
      result.status         = ST_ACCEPTED;
      result.error_code     = ERR_NONE;
      result.line_number    = OUT_BITS'(line_ff);
      result.prop_type      = '0;
      result.prop_size      = '0;
      result.nonprint_count = '0;
      result.object_count   = OUT_BITS'(obj_in);
      priority if (sticky_ff != ERR_NONE) begin
         result.status     = ST_ERROR;
         result.error_code = sticky_ff;
      end else if (phase_ff == PH_FINISHED) begin
         result.status = ST_FINISHED;
      end else if (kind) begin
         if (finish_ok) begin
            result.status = ST_FINISHED;
         end else begin
            result.status     = ST_ERROR;
            result.error_code = ERR_PREMATURE;
         end
      end else if (byte_err != ERR_NONE) begin
         result.status     = ST_ERROR;
         result.error_code = byte_err;
      end else if (prop_done) begin
         result.status         = ST_PROPERTY;
         result.prop_type      = OUT_BITS'(type_ff);
         result.prop_size      = OUT_BITS'(acc_ff);
         result.nonprint_count = OUT_BITS'(np_ff);
      end else if (obj_done) begin
         result.status = ST_OBJECT;
      end else begin
         result.status = ST_ACCEPTED;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HDR;
         match_ff  <= 4'd0;
         acc_ff    <= '0;
         type_ff   <= '0;
         remain_ff <= '0;
         np_ff     <= '0;
         line_ff   <= COUNT_BITS'(1);
         obj_ff    <= '0;
         sticky_ff <= ERR_NONE;
      end else if (accept) begin
         phase_ff  <= phase_in;
         match_ff  <= match_in;
         acc_ff    <= acc_in;
         type_ff   <= type_in;
         remain_ff <= remain_in;
         np_ff     <= np_in;
         line_ff   <= line_in;
         obj_ff    <= obj_in;
         sticky_ff <= sticky_in;
      end
   end

endmodule

[hdl/qrfc_out_buf.sv]
module qrfc_out_buf (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   input  qrfc_pkg::qrfc_result_type in_data,
   output logic                      full,
   output logic                      out_valid,
   output qrfc_pkg::qrfc_result_type out_data,
   input  logic                      out_stall
);
   import qrfc_pkg::*;

   logic            main_valid_ff, main_valid_in;
   logic            skid_valid_ff, skid_valid_in;
   qrfc_result_type main_data_ff, main_data_in;
   qrfc_result_type skid_data_ff, skid_data_in;
   logic            main_free;

   // The main register can load when it is empty or its word leaves this cycle.
   assign main_free = !main_valid_ff || !out_stall;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_data_in  = main_data_ff;
      skid_data_in  = skid_data_ff;
      if (main_free) begin
         if (skid_valid_ff) begin
            main_valid_in = 1'b1;
            main_data_in  = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            main_valid_in = in_valid;
            main_data_in  = in_data;
         end
      end else if (in_valid) begin
         skid_valid_in = 1'b1;
         skid_data_in  = in_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_data_ff <= main_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign full      = skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_data  = main_data_ff;

endmodule

[tb/queue_record_format_checker_test.sv]
`timescale 1ns / 1ps

module queue_record_format_checker_test;
   import qrfc_pkg::*;

   localparam int    CYCLE_LIMIT  = 200000;
   localparam int    STREAM_WORDS = 650;
   localparam string HEADER_TEXT  = "<Obj:1:msg:1:";
   localparam string CLOSE_TEXT   = ">End";

   typedef struct {
      logic       kind;
      logic [7:0] value;
      logic       pause;
   } file_word_type;

   // How the file is brought to its end.
   typedef enum int {
      WRAP_CLEAN, WRAP_DOT_AT_END, WRAP_BAD_START, WRAP_BAD_HEADER, WRAP_NO_PLUS,
      WRAP_NO_DOT, WRAP_NO_COLON, WRAP_NONDIGIT, WRAP_EXTRA_DATA, WRAP_PREMATURE
   } wrap_up_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_kind = 1'b0;
   logic [7:0]  req_byte_value = 8'd0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_status;
   logic [3:0]  rsp_error_code;
   logic [23:0] rsp_line_number;
   logic [23:0] rsp_prop_type;
   logic [23:0] rsp_prop_size;
   logic [23:0] rsp_nonprint_count;
   logic [23:0] rsp_object_count;

   file_word_type   file_stream[$];
   qrfc_result_type byte_verdicts[$];
   int              bytes_taken = 0;
   int              verdicts_seen = 0;
   int              mismatches = 0;
   int              cycle_count = 0;
   int              hold_cycles = 0;
   logic            held_once = 1'b0;
   logic            receiver_holding = 1'b0;

   // Parser state mirrored by the predictor.
   phase_type   ph;
   logic [3:0]  midx;
   logic [23:0] acc;
   logic [23:0] styp;
   logic [23:0] drem;
   logic [23:0] npc;
   logic [23:0] lines;
   logic [23:0] objs;
   err_type     sticky;

   queue_record_format_checker DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_kind           (req_kind),
      .req_byte_value     (req_byte_value),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_error_code     (rsp_error_code),
      .rsp_line_number    (rsp_line_number),
      .rsp_prop_type      (rsp_prop_type),
      .rsp_prop_size      (rsp_prop_size),
      .rsp_nonprint_count (rsp_nonprint_count),
      .rsp_object_count   (rsp_object_count)
   );

   always #6 clock = ~clock;

   function automatic logic [23:0] sat_inc(input logic [23:0] v);
      return (v == 24'hFFFFFF) ? v : v + 24'd1;
   endfunction

   task automatic clear_parser();
      ph = PH_HDR;
      midx = '0;
      acc = '0;
      styp = '0;
      drem = '0;
      npc = '0;
      lines = 24'd1;
      objs = '0;
      sticky = ERR_NONE;
   endtask

   task automatic parse_file_byte(input logic kind, input logic [7:0] b,
                                  output qrfc_result_type r);
      err_type     e;
      logic [31:0] v;
      e = ERR_NONE;
      r = '0;
      r.status = ST_ACCEPTED;
      r.error_code = ERR_NONE;
      r.line_number = lines;
      if (sticky != ERR_NONE) begin
         r.status = ST_ERROR;
         r.error_code = sticky;
      end else if (ph == PH_FINISHED) begin
         r.status = ST_FINISHED;
      end else if (kind) begin
         if (ph == PH_HDR && midx == 0) begin
            ph = PH_FINISHED;
            r.status = ST_FINISHED;
         end else if (ph == PH_DOT && midx == 1) begin
            objs = sat_inc(objs);
            ph = PH_FINISHED;
            r.status = ST_FINISHED;
         end else begin
            sticky = ERR_PREMATURE;
            r.status = ST_ERROR;
            r.error_code = ERR_PREMATURE;
         end
      end else begin
         case (ph)
            PH_HDR: begin
               if (midx < HEADER_TEXT.len()) begin
                  if (b == HEADER_TEXT[midx]) midx++;
                  else e = (midx == 0) ? ERR_BAD_START : ERR_BAD_HEADER;
               end else if (b == CHAR_NL) begin
                  ph = PH_LSTART;
                  midx = '0;
               end else begin
                  e = ERR_BAD_HEADER;
               end
            end
            PH_LSTART: begin
               if (b == CHAR_PLUS) begin
                  ph = PH_NAME;
               end else if (b == CHAR_GT) begin
                  ph = PH_END;
                  midx = 4'd1;
               end else begin
                  e = ERR_NO_PLUS;
               end
            end
            PH_END: begin
               if (midx < CLOSE_TEXT.len()) begin
                  if (b == CLOSE_TEXT[midx]) midx++;
                  else e = ERR_NO_PLUS;
               end else if (b == CHAR_NL) begin
                  ph = PH_DOT;
                  midx = '0;
               end else begin
                  e = ERR_NO_PLUS;
               end
            end
            PH_DOT: begin
               if (midx == 0) begin
                  if (b == CHAR_DOT) midx = 4'd1;
                  else e = ERR_NO_DOT;
               end else if (b == CHAR_NL) begin
                  objs = sat_inc(objs);
                  ph = PH_HDR;
                  midx = '0;
                  r.status = ST_OBJECT;
               end else begin
                  e = ERR_NO_DOT;
               end
            end
            PH_NAME: begin
               if (b == CHAR_COLON) begin
                  ph = PH_TYPE;
                  acc = '0;
               end else if (b == CHAR_NL) begin
                  e = ERR_NO_COLON;
               end
            end
            PH_TYPE, PH_SIZE: begin
               if (b == CHAR_COLON) begin
                  if (ph == PH_TYPE) begin
                     styp = acc;
                     acc = '0;
                     ph = PH_SIZE;
                  end else begin
                     drem = acc;
                     npc = '0;
                     ph = (drem == 0) ? PH_DCOLON : PH_DATA;
                  end
               end else if (b == CHAR_NL) begin
                  e = ERR_NO_COLON;
               end else if (b < CHAR_ZERO || b > CHAR_NINE) begin
                  e = ERR_NONDIGIT;
               end else begin
                  v = 32'(acc) * 32'd10 + 32'(b - CHAR_ZERO);
                  acc = (v > 32'h00FF_FFFF) ? 24'hFFFFFF : v[23:0];
               end
            end
            PH_DATA: begin
               if (b < CHAR_SPACE || b > CHAR_TILDE) npc = sat_inc(npc);
               if (drem != 0) drem--;
               if (drem == 0) ph = PH_DCOLON;
               if (b == CHAR_NL) lines = sat_inc(lines);
            end
            PH_DCOLON: begin
               if (b == CHAR_COLON) ph = PH_PEND;
               else e = ERR_NO_COLON;
            end
            PH_PEND: begin
               if (b == CHAR_NL) begin
                  ph = PH_LSTART;
                  r.status = ST_PROPERTY;
                  r.prop_type = styp;
                  r.prop_size = acc;
                  r.nonprint_count = npc;
               end else begin
                  e = ERR_EXTRA_DATA;
               end
            end
            default: e = ERR_BAD_HEADER;
         endcase
         if (e != ERR_NONE) begin
            sticky = e;
            r = '0;
            r.status = ST_ERROR;
            r.error_code = e;
            r.line_number = lines;
         end else if (b == CHAR_NL && ph != PH_DATA && ph != PH_DCOLON) begin
            // Newlines inside data were already counted above.
            lines = sat_inc(lines);
         end
      end
      r.object_count = objs;
   endtask

   task automatic put_word(input logic kind, input logic [7:0] value);
      file_word_type w;
      w.kind = kind;
      w.value = value;
      w.pause = 1'b0;
      file_stream.push_back(w);
   endtask

   task automatic put_byte(input logic [7:0] value);
      put_word(1'b0, value);
   endtask

   task automatic put_end();
      put_word(1'b1, 8'($urandom_range(0, 255)));
   endtask

   task automatic put_pause();
      file_word_type w;
      w.kind = 1'b0;
      w.value = 8'd0;
      w.pause = 1'b1;
      file_stream.push_back(w);
   endtask

   task automatic put_text(input string s);
      for (int i = 0; i < s.len(); i++) put_byte(s[i]);
   endtask

   task automatic put_header();
      put_text(HEADER_TEXT);
      put_byte(CHAR_NL);
   endtask

   function automatic logic [7:0] pick_other(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] c;
      do c = 8'($urandom_range(0, 255)); while (c == a || c == b);
      return c;
   endfunction

   function automatic logic [7:0] pick_nondigit();
      logic [7:0] c;
      do c = 8'($urandom_range(0, 255));
      while ((c >= CHAR_ZERO && c <= CHAR_NINE) || c == CHAR_COLON || c == CHAR_NL);
      return c;
   endfunction

   function automatic logic [7:0] data_byte();
      int unsigned sel;
      sel = $urandom_range(0, 7);
      if (sel == 0) return CHAR_NL;
      if (sel < 3) return 8'($urandom_range(0, 255));
      return 8'($urandom_range(CHAR_SPACE, CHAR_TILDE));
   endfunction

   function automatic string type_text();
      int unsigned sel;
      sel = $urandom_range(0, 9);
      if (sel == 0) return "";
      if (sel == 1) return "99999999999";
      if (sel == 2) return $sformatf("%0d", $urandom());
      if (sel == 3) return $sformatf("00%0d", $urandom_range(0, 99));
      return $sformatf("%0d", $urandom_range(0, 999));
   endfunction

   task automatic put_random_property();
      int unsigned size;
      put_byte(CHAR_PLUS);
      repeat ($urandom_range(0, 5)) put_byte(pick_other(CHAR_COLON, CHAR_NL));
      put_byte(CHAR_COLON);
      put_text(type_text());
      put_byte(CHAR_COLON);
      size = ($urandom_range(0, 19) == 0) ? $urandom_range(30, 120) : $urandom_range(0, 10);
      // An empty size field reads as zero.
      if (size != 0 || $urandom_range(0, 1) != 0) begin
         if ($urandom_range(0, 5) == 0) put_byte(CHAR_ZERO);
         put_text($sformatf("%0d", size));
      end
      put_byte(CHAR_COLON);
      repeat (size) put_byte(data_byte());
      put_byte(CHAR_COLON);
      put_byte(CHAR_NL);
   endtask

   task automatic put_object(input int unsigned props);
      put_header();
      repeat (props) put_random_property();
      put_text(CLOSE_TEXT);
      put_byte(CHAR_NL);
      put_byte(CHAR_DOT);
      put_byte(CHAR_NL);
   endtask

   // Ends the file either cleanly or with one of the sticky errors.
   task automatic put_wrap_up();
      wrap_up_type how;
      int unsigned k;
      int unsigned start;
      int unsigned cut;
      how = wrap_up_type'($urandom_range(0, 9));
      case (how)
         WRAP_CLEAN: put_end();
         WRAP_DOT_AT_END: begin
            put_header();
            repeat ($urandom_range(0, 2)) put_random_property();
            put_text(CLOSE_TEXT);
            put_byte(CHAR_NL);
            put_byte(CHAR_DOT);
            put_end();
         end
         WRAP_BAD_START: begin
            put_byte(($urandom_range(0, 1) != 0) ? CHAR_NL : pick_other(CHAR_LT, CHAR_LT));
         end
         WRAP_BAD_HEADER: begin
            k = $urandom_range(1, HEADER_TEXT.len());
            for (int i = 0; i < k; i++) put_byte(HEADER_TEXT[i]);
            if (k < HEADER_TEXT.len())
               put_byte(pick_other(HEADER_TEXT[k], HEADER_TEXT[k]));
            else
               put_byte(pick_other(CHAR_NL, CHAR_NL));
         end
         WRAP_NO_PLUS: begin
            put_header();
            repeat ($urandom_range(0, 1)) put_random_property();
            k = $urandom_range(0, 2);
            if (k == 0) begin
               put_byte(($urandom_range(0, 2) == 0) ? CHAR_NL
                                                   : pick_other(CHAR_PLUS, CHAR_GT));
            end else if (k == 1) begin
               k = $urandom_range(1, CLOSE_TEXT.len() - 1);
               for (int i = 0; i < k; i++) put_byte(CLOSE_TEXT[i]);
               put_byte(pick_other(CLOSE_TEXT[k], CLOSE_TEXT[k]));
            end else begin
               put_text(CLOSE_TEXT);
               put_byte(pick_other(CHAR_NL, CHAR_NL));
            end
         end
         WRAP_NO_DOT: begin
            put_header();
            put_text(CLOSE_TEXT);
            put_byte(CHAR_NL);
            if ($urandom_range(0, 1) != 0) begin
               put_byte(pick_other(CHAR_DOT, CHAR_DOT));
            end else begin
               put_byte(CHAR_DOT);
               put_byte(pick_other(CHAR_NL, CHAR_NL));
            end
         end
         WRAP_NO_COLON: begin
            put_header();
            k = $urandom_range(0, 4);
            if (k == 0) put_text("+ab");
            else if (k == 1) put_text("+ab:12");
            else if (k == 2) put_text("+ab:12:3");
            else if (k == 3) put_text("+a:1:2:xy");
            else put_text("+a:1:0:");
            put_byte((k < 3) ? CHAR_NL : pick_other(CHAR_COLON, CHAR_COLON));
         end
         WRAP_NONDIGIT: begin
            put_header();
            put_text(($urandom_range(0, 1) != 0) ? "+a:12" : "+a:12:3");
            put_byte(pick_nondigit());
         end
         WRAP_EXTRA_DATA: begin
            put_header();
            put_text("+a:1:1:x:");
            put_byte(pick_other(CHAR_NL, CHAR_NL));
         end
         default: begin
            if ($urandom_range(0, 3) == 0) begin
               // A saturated size leaves the parser inside the data.
               put_header();
               put_text("+:0:99999999999:");
               repeat ($urandom_range(0, 5)) put_byte(data_byte());
            end else begin
               start = file_stream.size();
               put_object($urandom_range(1, 2));
               cut = $urandom_range(1, file_stream.size() - start - 2);
               while (file_stream.size() > start + cut) void'(file_stream.pop_back());
            end
            put_end();
         end
      endcase
      // Everything after the end must repeat the final answer.
      repeat (5) put_word(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
   endtask

   task automatic compare_field(input string name, input logic [23:0] want,
                                input logic [23:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endtask

   // Sender.
   always @(posedge clock) begin
      qrfc_result_type verdict;
      logic            calm;
      if (reset) begin
         clear_parser();
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            parse_file_byte(req_kind, req_byte_value, verdict);
            byte_verdicts.push_back(verdict);
            void'(file_stream.pop_front());
            bytes_taken++;
         end
         if (file_stream.size() != 0 && file_stream[0].pause && byte_verdicts.size() == 0)
            void'(file_stream.pop_front());
         calm = (bytes_taken >= 150 && bytes_taken < 300) || receiver_holding;
         // A stalled word is held as it is.
         if (!(req_valid && req_stall)) begin
            if (file_stream.size() != 0 && !file_stream[0].pause &&
                (calm || $urandom_range(0, 99) >= 31)) begin
               req_valid <= 1'b1;
               req_kind <= file_stream[0].kind;
               req_byte_value <= file_stream[0].value;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver and checker.
   always @(posedge clock) begin
      qrfc_result_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            verdicts_seen++;
            if (byte_verdicts.size() == 0) begin
               $error("result word with no prediction waiting: status %0d", rsp_status);
               mismatches++;
            end else begin
               want = byte_verdicts.pop_front();
               compare_field("status", want.status, rsp_status);
               compare_field("error_code", want.error_code, rsp_error_code);
               compare_field("line_number", want.line_number, rsp_line_number);
               compare_field("prop_type", want.prop_type, rsp_prop_type);
               compare_field("prop_size", want.prop_size, rsp_prop_size);
               compare_field("nonprint_count", want.nonprint_count, rsp_nonprint_count);
               compare_field("object_count", want.object_count, rsp_object_count);
            end
         end
         if (verdicts_seen == 350 && !held_once) begin
            hold_cycles = 80;
            held_once = 1'b1;
         end
         if (hold_cycles != 0) begin
            hold_cycles--;
            rsp_stall <= 1'b1;
         end else if (verdicts_seen >= 150 && verdicts_seen < 300) begin
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < 31);
         end
         receiver_holding <= (hold_cycles != 0);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("queue_record_format_checker verification failed");
         $finish;
      end
   end

   initial begin
      // Opening object: empty name, saturated type, zero size, then data that
      // sits on every printable boundary and holds a newline.
      put_header();
      put_text("+:99999999999:0::");
      put_byte(CHAR_NL);
      put_byte(CHAR_PLUS);
      put_byte(8'hFF);
      put_byte(8'h00);
      put_text(":7:7:");
      put_byte(8'h00);
      put_byte(8'h1F);
      put_byte(CHAR_SPACE);
      put_byte(CHAR_TILDE);
      put_byte(8'h7F);
      put_byte(8'hFF);
      put_byte(CHAR_NL);
      put_byte(CHAR_COLON);
      put_byte(CHAR_NL);
      put_text(CLOSE_TEXT);
      put_byte(CHAR_NL);
      put_byte(CHAR_DOT);
      put_byte(CHAR_NL);
      put_pause();
      while (file_stream.size() < STREAM_WORDS) begin
         put_object($urandom_range(0, 4));
         if (file_stream.size() > 400 && file_stream.size() < 460) put_pause();
      end
      put_pause();
      put_wrap_up();

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      while (file_stream.size() != 0 || byte_verdicts.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatches == 0)
         $display("queue_record_format_checker verification clean");
      else
         $display("queue_record_format_checker verification failed");
      $finish;
   end

endmodule
